// ----- rtl/ubdc_pkg.sv -----
package ubdc_pkg;

  // Field and datapath widths
  localparam int BAUD_W     = 24;
  localparam int CLK_W      = 28;
  localparam int INT_W      = 16;
  localparam int FRAC_W     = 6;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 28;
  localparam int NUM_W      = 32;  // 8*clock + baud
  localparam int SH_W       = 4;   // right shift applied to the numerator
  localparam int M_W        = 29;  // shifted numerator
  localparam int Q_W        = 23;  // divisor in 64ths
  localparam int MAGIC_W    = 32;
  localparam int DIV_W      = 8;
  localparam int NUM_RATES  = 14;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_REF_CLOCK = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DEF_INT   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DEF_FRAC  = 2'd2;

  // Register reset values
  localparam logic [CLK_W-1:0]  RST_REF_CLOCK = 28'd48000000;
  localparam logic [INT_W-1:0]  RST_DEF_INT   = 16'd26;
  localparam logic [FRAC_W-1:0] RST_DEF_FRAC  = 6'd3;

  localparam logic [INT_W-1:0]  INT_MAX  = '1;
  localparam logic [FRAC_W-1:0] FRAC_MAX = '1;

  // Every supported rate is 300 * 2^k or 900 * 2^k, so 2*baud is
  // 75 * 2^(3+k) or 225 * 2^(3+k): a shift followed by a division by
  // one of two constants.
  localparam logic [DIV_W-1:0] DIV_75  = 8'd75;
  localparam logic [DIV_W-1:0] DIV_225 = 8'd225;

  // Reciprocals floor(2^37/75) and floor(2^39/225); estimate is q or q-1
  localparam logic [MAGIC_W-1:0] MAGIC_75  = 32'd1832519379;
  localparam logic [MAGIC_W-1:0] MAGIC_225 = 32'd2443359172;
  localparam int MAGIC_SH_75  = 37;
  localparam int MAGIC_SH_225 = 39;

  typedef struct packed {
    logic [BAUD_W-1:0] rate;
    logic [SH_W-1:0]   shift;
    logic              div3;
  } rate_entry_t;

  localparam rate_entry_t RATE_TABLE [NUM_RATES] = '{
    '{24'd300,    4'd3,  1'b0},
    '{24'd600,    4'd4,  1'b0},
    '{24'd1200,   4'd5,  1'b0},
    '{24'd2400,   4'd6,  1'b0},
    '{24'd4800,   4'd7,  1'b0},
    '{24'd9600,   4'd8,  1'b0},
    '{24'd14400,  4'd7,  1'b1},
    '{24'd19200,  4'd9,  1'b0},
    '{24'd38400,  4'd10, 1'b0},
    '{24'd57600,  4'd9,  1'b1},
    '{24'd115200, 4'd10, 1'b1},
    '{24'd230400, 4'd11, 1'b1},
    '{24'd460800, 4'd12, 1'b1},
    '{24'd921600, 4'd13, 1'b1}
  };

  // Control travelling with each word down the pipeline
  typedef struct packed {
    logic valid;
    logic supported;
    logic div3;
  } ctl_t;

endpackage

// ----- rtl/ubdc_lookup.sv -----
module ubdc_lookup (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic [ubdc_pkg::BAUD_W-1:0]   in_baud,
  input  logic [ubdc_pkg::CLK_W-1:0]    ref_clock,
  output ubdc_pkg::ctl_t                ctl_o,
  output logic [ubdc_pkg::SH_W-1:0]     shift_o,
  output logic [ubdc_pkg::NUM_W-1:0]    num_o
);

  ubdc_pkg::ctl_t                  ctl_r, ctl_nxt;
  logic [ubdc_pkg::SH_W-1:0]       shift_r, shift_nxt;
  logic [ubdc_pkg::NUM_W-1:0]      num_r, num_nxt;

  // Match the rate against the table and form 8*clock + baud
  always_comb begin
    ctl_nxt   = '0;
    shift_nxt = '0;
    ctl_nxt.valid = in_valid;
    for (int i = 0; i < ubdc_pkg::NUM_RATES; i++) begin
      if (in_baud == ubdc_pkg::RATE_TABLE[i].rate) begin
        ctl_nxt.supported = 1'b1;
        ctl_nxt.div3      = ubdc_pkg::RATE_TABLE[i].div3;
        shift_nxt         = ubdc_pkg::RATE_TABLE[i].shift;
      end
    end
    num_nxt = (ubdc_pkg::NUM_W'(ref_clock) << 3) + ubdc_pkg::NUM_W'(in_baud);
  end

  // Hold valid under reset, payload free-running
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else begin
      ctl_r <= ctl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    shift_r <= shift_nxt;
    num_r   <= num_nxt;
  end

  assign ctl_o   = ctl_r;
  assign shift_o = shift_r;
  assign num_o   = num_r;

endmodule

// ----- rtl/ubdc_recip_div.sv -----
module ubdc_recip_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  ubdc_pkg::ctl_t                ctl_i,
  input  logic [ubdc_pkg::SH_W-1:0]     shift_i,
  input  logic [ubdc_pkg::NUM_W-1:0]    num_i,
  output ubdc_pkg::ctl_t                ctl_o,
  output logic [ubdc_pkg::Q_W-1:0]      quot_o
);

  localparam int PROD_W = ubdc_pkg::M_W + ubdc_pkg::MAGIC_W;
  localparam int QD_W   = ubdc_pkg::Q_W + ubdc_pkg::DIV_W;
  localparam int REM_W  = ubdc_pkg::M_W + 1;

  ubdc_pkg::ctl_t                  ctl2_r, ctl3_r, ctl4_r;
  logic [ubdc_pkg::M_W-1:0]        m2_r, m2_nxt;
  logic [ubdc_pkg::M_W-1:0]        m3_r;
  logic [ubdc_pkg::Q_W-1:0]        qe3_r, qe3_nxt;
  logic [ubdc_pkg::Q_W-1:0]        q4_r, q4_nxt;
  logic [ubdc_pkg::MAGIC_W-1:0]    magic;
  logic [PROD_W-1:0]               prod;
  logic [ubdc_pkg::DIV_W-1:0]      dv;
  logic [QD_W-1:0]                 qd;
  logic [REM_W-1:0]                rem;

  // Stage 2: drop the power-of-two part of the divisor
  assign m2_nxt = ubdc_pkg::M_W'(num_i >> shift_i);

  // Stage 3: multiply by the reciprocal of 75 or 225
  always_comb begin
    magic = ctl2_r.div3 ? ubdc_pkg::MAGIC_225 : ubdc_pkg::MAGIC_75;
    prod  = PROD_W'(m2_r) * PROD_W'(magic);
    if (ctl2_r.div3) begin
      qe3_nxt = ubdc_pkg::Q_W'(prod >> ubdc_pkg::MAGIC_SH_225);
    end else begin
      qe3_nxt = ubdc_pkg::Q_W'(prod >> ubdc_pkg::MAGIC_SH_75);
    end
  end

  // Stage 4: the estimate may be one short; fix it from the remainder
  always_comb begin
    dv  = ctl3_r.div3 ? ubdc_pkg::DIV_225 : ubdc_pkg::DIV_75;
    qd  = QD_W'(qe3_r) * QD_W'(dv);
    rem = REM_W'(m3_r) - REM_W'(qd);
    q4_nxt = qe3_r;
    if (rem >= REM_W'(dv)) begin
      q4_nxt = qe3_r + 1'b1;
    end
  end

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl2_r <= '0;
      ctl3_r <= '0;
      ctl4_r <= '0;
    end else begin
      ctl2_r <= ctl_i;
      ctl3_r <= ctl2_r;
      ctl4_r <= ctl3_r;
    end
  end

  // Advance payload
  always_ff @(posedge clk) begin
    m2_r  <= m2_nxt;
    m3_r  <= m2_r;
    qe3_r <= qe3_nxt;
    q4_r  <= q4_nxt;
  end

  assign ctl_o  = ctl4_r;
  assign quot_o = q4_r;

endmodule

// ----- rtl/uart_baud_divisor_calc.sv -----
// Baud divisor calculator. Throughput one word per cycle; five register
// stages (table match, shift, reciprocal multiply, correction, output
// select) lie between start and out_valid.
// busy is never asserted and results cannot be held off.
// Synchronous active-low reset clears the valid bits and loads the
// register defaults (48 MHz clock, default divisor 26 + 3/64).
module uart_baud_divisor_calc (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic [ubdc_pkg::BAUD_W-1:0]       in_baud_rate,
  input  logic                              cfg_we,
  input  logic [ubdc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [ubdc_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  output logic                              out_valid,
  output logic [ubdc_pkg::INT_W-1:0]        out_int_divisor,
  output logic [ubdc_pkg::FRAC_W-1:0]       out_frac_divisor,
  output logic                              out_rate_supported
);

  localparam int IPART_W = ubdc_pkg::Q_W - ubdc_pkg::FRAC_W;

  logic [ubdc_pkg::CLK_W-1:0]      ref_clock_r;
  logic [ubdc_pkg::INT_W-1:0]      def_int_r;
  logic [ubdc_pkg::FRAC_W-1:0]     def_frac_r;

  ubdc_pkg::ctl_t                  ctl1, ctl4;
  logic [ubdc_pkg::SH_W-1:0]       shift1;
  logic [ubdc_pkg::NUM_W-1:0]      num1;
  logic [ubdc_pkg::Q_W-1:0]        quot4;
  logic [IPART_W-1:0]              ipart;

  logic                            out_valid_r;
  logic [ubdc_pkg::INT_W-1:0]      int_r, int_nxt;
  logic [ubdc_pkg::FRAC_W-1:0]     frac_r, frac_nxt;
  logic                            sup_r;

  assign busy = 1'b0;

  // Configuration registers; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ref_clock_r <= ubdc_pkg::RST_REF_CLOCK;
      def_int_r   <= ubdc_pkg::RST_DEF_INT;
      def_frac_r  <= ubdc_pkg::RST_DEF_FRAC;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ubdc_pkg::CFG_REF_CLOCK: ref_clock_r <= cfg_wdata;
        ubdc_pkg::CFG_DEF_INT:   def_int_r   <= ubdc_pkg::INT_W'(cfg_wdata);
        ubdc_pkg::CFG_DEF_FRAC:  def_frac_r  <= ubdc_pkg::FRAC_W'(cfg_wdata);
        default: ;
      endcase
    end
  end

  ubdc_lookup u_lookup (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (start),
    .in_baud   (in_baud_rate),
    .ref_clock (ref_clock_r),
    .ctl_o     (ctl1),
    .shift_o   (shift1),
    .num_o     (num1)
  );

  ubdc_recip_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl_i   (ctl1),
    .shift_i (shift1),
    .num_i   (num1),
    .ctl_o   (ctl4),
    .quot_o  (quot4)
  );

  // Split the quotient, saturate the integer part, or pick the defaults
  always_comb begin
    ipart = quot4[ubdc_pkg::Q_W-1:ubdc_pkg::FRAC_W];
    if (!ctl4.supported) begin
      int_nxt  = def_int_r;
      frac_nxt = def_frac_r;
    end else if (ipart > IPART_W'(ubdc_pkg::INT_MAX)) begin
      int_nxt  = ubdc_pkg::INT_MAX;
      frac_nxt = ubdc_pkg::FRAC_MAX;
    end else begin
      int_nxt  = ubdc_pkg::INT_W'(ipart);
      frac_nxt = quot4[ubdc_pkg::FRAC_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= ctl4.valid;
    end
  end

  // Hold the last word between strobes
  always_ff @(posedge clk) begin
    if (ctl4.valid) begin
      int_r  <= int_nxt;
      frac_r <= frac_nxt;
      sup_r  <= ctl4.supported;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_int_divisor    = int_r;
  assign out_frac_divisor   = frac_r;
  assign out_rate_supported = sup_r;

`ifndef SYNTHESIS
  // Every accepted word comes out with a result strobe
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##5 out_valid)
    else $error("result strobe missing five cycles after start");

  // No strobe without a matching accepted word
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start, 5))
    else $error("result strobe without a matching start");

  // Unsupported rates return the stored defaults
  a_defaults: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_rate_supported) |->
      (out_int_divisor == def_int_r && out_frac_divisor == def_frac_r))
    else $error("unsupported rate did not return the default divisors");
`endif

endmodule
